// ===== hw/rtl/tcgr_pkg.sv =====
// Shared types and constants for the text console glyph renderer.
// No dependencies; imported by tcgr_ctrl, tcgr_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tcgr_pkg;

	// Font geometry defaults and fixed cell width
	localparam int GLYPH_ROWS_DEF = 16;
	localparam int CHAR_COUNT_DEF = 256;
	localparam int GLYPH_COLUMNS  = 8;
	localparam int CELL_SH        = $clog2(GLYPH_COLUMNS);

	// Field widths
	localparam int CUR_W   = 13;
	localparam int PIX_W   = 12;
	localparam int CODE_W  = 8;
	localparam int GROW_W  = 4;
	localparam int BITS_W  = 8;
	localparam int COLOR_W = 32;
	localparam int ADDR_W  = 32;
	localparam int IDX_W   = 3;
	localparam int CDATA_W = 32;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 128;

	// Input command selector
	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_FONT = 1'b1;

	// Result kinds
	localparam logic KIND_ROW   = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// Control character codes
	localparam logic [CODE_W-1:0] CH_NUL = 8'd0;
	localparam logic [CODE_W-1:0] CH_BS  = 8'd8;
	localparam logic [CODE_W-1:0] CH_TAB = 8'd9;
	localparam logic [CODE_W-1:0] CH_LF  = 8'd10;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_PITCH  = 3'd2;
	localparam logic [IDX_W-1:0] REG_BPP    = 3'd3;
	localparam logic [IDX_W-1:0] REG_FORE   = 3'd4;
	localparam logic [IDX_W-1:0] REG_BACK   = 3'd5;
	localparam logic [IDX_W-1:0] REG_TAB    = 3'd6;

	// Controller to datapath commands
	typedef struct packed {
		logic font_wr;
		logic take_code;
		logic push_clear;
		logic clr_last;
		logic push_row;
		logic row_first;
		logic row_last;
		logic do_move;
		logic do_setup;
		logic do_adv;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_clear;
		logic is_ctrl;
		logic advance;
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcgr_ctrl.sv =====
// Sequencer for the text console: input handshake, clear check, row issue.
// Depends on tcgr_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module tcgr_ctrl #(
	parameter int GLYPH_ROWS = tcgr_pkg::GLYPH_ROWS_DEF,
	parameter int ROW_W      = $clog2(GLYPH_ROWS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic              s_cmd,
	input  wire tcgr_pkg::status_t status,
	output tcgr_pkg::cmd_t         cmd,
	output logic [ROW_W-1:0]       row
);
	import tcgr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MOVE,
		ST_SETUP,
		ST_ROWS,
		ST_ADV
	} state_t;

	state_t           state_q;
	logic [ROW_W-1:0] row_q;
	logic             accept;
	logic             row_end;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign row_end  = (row_q == ROW_W'(GLYPH_ROWS - 1));
	assign row      = row_q;

	// Decode commands from state and status
	always_comb begin
		cmd            = '0;
		cmd.font_wr    = accept & (s_cmd == CMD_FONT);
		cmd.take_code  = accept & (s_cmd == CMD_PUT);
		cmd.push_clear = (state_q == ST_CHECK) & status.need_clear & status.advance;
		cmd.clr_last   = status.is_ctrl;
		cmd.push_row   = (state_q == ST_ROWS) & status.advance;
		cmd.row_first  = (row_q == '0);
		cmd.row_last   = row_end;
		cmd.do_move    = (state_q == ST_MOVE);
		cmd.do_setup   = (state_q == ST_SETUP);
		cmd.do_adv     = (state_q == ST_ADV);
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.take_code)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!status.need_clear || status.advance)
						state_q <= status.is_ctrl ? ST_MOVE : ST_SETUP;
				end
				ST_MOVE: state_q <= ST_IDLE;
				ST_SETUP: begin
					row_q   <= '0;
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					if (status.advance) begin
						if (row_end)
							state_q <= ST_ADV;
						else
							row_q <= row_q + ROW_W'(1);
					end
				end
				ST_ADV: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tcgr_datapath.sv =====
// Datapath: registers, cursor, font memory, address pipeline and output beat.
// Depends on tcgr_pkg for constants and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module tcgr_datapath #(
	parameter int GLYPH_ROWS = tcgr_pkg::GLYPH_ROWS_DEF,
	parameter int CHAR_COUNT = tcgr_pkg::CHAR_COUNT_DEF,
	parameter int ROW_W      = $clog2(GLYPH_ROWS)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tcgr_pkg::cmd_t                 cmd,
	input  wire logic [ROW_W-1:0]               row,
	output tcgr_pkg::status_t                   status,
	input  wire logic [tcgr_pkg::CODE_W-1:0]    in_code,
	input  wire logic [tcgr_pkg::GROW_W-1:0]    in_grow,
	input  wire logic [tcgr_pkg::BITS_W-1:0]    in_bits,
	input  wire logic                           cfg_valid,
	input  wire logic [tcgr_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [tcgr_pkg::CDATA_W-1:0]   cfg_data,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic                                m_kind,
	output logic                                m_last,
	output logic [tcgr_pkg::PIX_W-1:0]          m_x,
	output logic [tcgr_pkg::PIX_W-1:0]          m_y,
	output logic [tcgr_pkg::ADDR_W-1:0]         m_addr,
	output logic [tcgr_pkg::BITS_W-1:0]         m_bits,
	output logic [tcgr_pkg::COLOR_W-1:0]        m_set,
	output logic [tcgr_pkg::COLOR_W-1:0]        m_clr
);
	import tcgr_pkg::*;

	localparam int FONT_DEPTH = CHAR_COUNT * GLYPH_ROWS;
	localparam int FIDX_W     = $clog2(FONT_DEPTH);
	localparam int LIN_W      = CODE_W + $clog2(GLYPH_ROWS) + 2;
	localparam int YM_W       = CUR_W + 16;
	localparam int XM_W       = CUR_W + 3;

	// Configuration registers
	logic [CUR_W-1:0]   width_q, height_q;
	logic [15:0]        pitch_q;
	logic [2:0]         bpp_q;
	logic [COLOR_W-1:0] fore_q, back_q;
	logic [4:0]         tab_q;

	// Cursor and current code
	logic [CUR_W-1:0]  cur_x_q, cur_y_q;
	logic [CODE_W-1:0] code_q;

	// Font memory and address terms
	logic [BITS_W-1:0] font_mem [FONT_DEPTH];
	logic [YM_W-1:0]   ymul_q;
	logic [XM_W-1:0]   xmul_q;

	// Read stage
	logic               valid_s1, kind_s1, zero_s1, last_s1;
	logic [PIX_W-1:0]   x_s1, y_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [BITS_W-1:0]  bits_s1;

	// Output beat
	logic               out_valid_q, out_kind_q, out_last_q;
	logic [PIX_W-1:0]   out_x_q, out_y_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [BITS_W-1:0]  out_bits_q;
	logic [COLOR_W-1:0] out_set_q, out_clr_q;

	logic               out_free, advance;
	logic [LIN_W-1:0]   wr_lin, rd_lin;
	logic               wr_ok, rd_ok;
	logic [CUR_W-1:0]   gr13, step_x, tab_x, nx, ny;
	logic [CUR_W:0]     clr_sum;
	logic [CUR_W-CELL_SH-1:0] cells;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = !valid_s1 || out_free;

	// Status back to the sequencer
	assign clr_sum = {1'b0, cur_y_q} + (CUR_W + 1)'(GLYPH_ROWS);
	always_comb begin
		status.need_clear = clr_sum > {1'b0, height_q};
		status.is_ctrl    = (code_q == CH_TAB) || (code_q == CH_LF) ||
		                    (code_q == CH_BS) || (code_q == CH_NUL);
		status.advance    = advance;
	end

	// Font store addressing
	assign wr_lin = LIN_W'(in_code) * LIN_W'(GLYPH_ROWS) + LIN_W'(in_grow);
	assign wr_ok  = (LIN_W'(in_code) < LIN_W'(CHAR_COUNT)) &&
	                (LIN_W'(in_grow) < LIN_W'(GLYPH_ROWS));
	assign rd_lin = LIN_W'(code_q) * LIN_W'(GLYPH_ROWS) + LIN_W'(row);
	assign rd_ok  = LIN_W'(code_q) < LIN_W'(CHAR_COUNT);

	// Next cursor for control codes and advance
	assign gr13   = CUR_W'(GLYPH_ROWS);
	assign step_x = cur_x_q + CUR_W'(GLYPH_COLUMNS);
	assign tab_x  = cur_x_q + (CUR_W'(tab_q) << CELL_SH);
	assign cells  = width_q[CUR_W-1:CELL_SH];
	always_comb begin
		nx = cur_x_q;
		ny = cur_y_q;
		if (cmd.do_adv) begin
			if (({1'b0, step_x} + (CUR_W + 1)'(GLYPH_COLUMNS)) > {1'b0, width_q}) begin
				nx = '0;
				ny = cur_y_q + gr13;
			end else begin
				nx = step_x;
			end
		end else begin
			case (code_q)
				CH_TAB: begin
					if (({1'b0, tab_x} + (CUR_W + 1)'(GLYPH_COLUMNS)) > {1'b0, width_q}) begin
						nx = '0;
						ny = cur_y_q + gr13;
					end else begin
						nx = tab_x;
					end
				end
				CH_LF: begin
					nx = '0;
					ny = cur_y_q + gr13;
				end
				CH_BS: begin
					if (cur_x_q == '0 && cur_y_q != '0) begin
						nx = (cells != '0) ?
						     {cells - (CUR_W - CELL_SH)'(1), CELL_SH'(0)} : '0;
						ny = (cur_y_q >= gr13) ? cur_y_q - gr13 : '0;
					end else if (cur_x_q != '0) begin
						nx = (cur_x_q >= CUR_W'(GLYPH_COLUMNS)) ?
						     cur_x_q - CUR_W'(GLYPH_COLUMNS) : '0;
					end
				end
				default: begin
					nx = cur_x_q;
					ny = cur_y_q;
				end
			endcase
		end
	end

	// Configuration, cursor and clear handling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			height_q <= 13'd480;
			pitch_q  <= 16'd2560;
			bpp_q    <= 3'd4;
			fore_q   <= '1;
			back_q   <= '0;
			tab_q    <= 5'd4;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data[CUR_W-1:0];
					REG_HEIGHT: height_q <= cfg_data[CUR_W-1:0];
					REG_PITCH:  pitch_q  <= cfg_data[15:0];
					REG_BPP:    bpp_q    <= cfg_data[2:0];
					REG_FORE:   fore_q   <= cfg_data;
					REG_BACK:   back_q   <= cfg_data;
					REG_TAB:    tab_q    <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (cmd.push_clear) begin
				back_q  <= '0;
				cur_x_q <= '0;
				cur_y_q <= '0;
			end else if (cmd.do_move || cmd.do_adv) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
			end
		end
	end

	// Latch code, form address terms, write and read font
	always_ff @(posedge clk) begin
		if (cmd.take_code)
			code_q <= in_code;
		if (cmd.do_setup) begin
			ymul_q <= YM_W'(cur_y_q) * YM_W'(pitch_q);
			xmul_q <= XM_W'(cur_x_q) * XM_W'(bpp_q);
		end
		if (cmd.font_wr && wr_ok)
			font_mem[wr_lin[FIDX_W-1:0]] <= in_bits;
		if (cmd.push_row && rd_ok)
			bits_s1 <= font_mem[rd_lin[FIDX_W-1:0]];
	end

	// Read stage: hold while the output beat is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cmd.push_clear || cmd.push_row;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (cmd.push_clear) begin
				kind_s1 <= KIND_CLEAR;
				last_s1 <= cmd.clr_last;
				zero_s1 <= 1'b1;
				x_s1    <= '0;
				y_s1    <= '0;
				addr_s1 <= '0;
			end else if (cmd.push_row) begin
				kind_s1 <= KIND_ROW;
				last_s1 <= cmd.row_last;
				zero_s1 <= !rd_ok;
				x_s1    <= cur_x_q[PIX_W-1:0];
				if (cmd.row_first) begin
					y_s1    <= cur_y_q[PIX_W-1:0];
					addr_s1 <= ADDR_W'(ymul_q) + ADDR_W'(xmul_q);
				end else begin
					y_s1    <= y_s1 + PIX_W'(1);
					addr_s1 <= addr_s1 + ADDR_W'(pitch_q);
				end
			end
		end
	end

	// Output beat: load when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_kind_q <= kind_s1;
			out_last_q <= last_s1;
			out_x_q    <= x_s1;
			out_y_q    <= y_s1;
			out_addr_q <= addr_s1;
			out_bits_q <= zero_s1 ? '0 : bits_s1;
			out_set_q  <= (kind_s1 == KIND_CLEAR) ? '0 : fore_q;
			out_clr_q  <= (kind_s1 == KIND_CLEAR) ? '0 : back_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_kind   = out_kind_q;
	assign m_last   = out_last_q;
	assign m_x      = out_x_q;
	assign m_y      = out_y_q;
	assign m_addr   = out_addr_q;
	assign m_bits   = out_bits_q;
	assign m_set    = out_set_q;
	assign m_clr    = out_clr_q;

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_glyph_renderer_top.sv =====
// Top level of the text console glyph renderer: ports, packing, assertions.
// Depends on tcgr_pkg, tcgr_ctrl and tcgr_datapath.
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  s_tuser command, s_tdata code/row/bits
//  m_*      out        m_tvalid / m_tready  m_tuser kind, m_tdata, m_tlast
//  cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A font write leaves the input ready. A control code passes the check and
// move states back to ready; a clear beat in front is pushed from the check
// state, which waits only while the row stage is stalled. A printable code
// passes check, setup, the row state once per glyph row, then advance; the
// font memory's single read port gives one glyph row per cycle unless stalled.
// Reset clears control state and presets the registers; the font store is kept.
// A stalled output holds its beat and the row stage behind it; input waits.
`timescale 1ns / 1ps
`default_nettype none

module text_console_glyph_renderer_top #(
	parameter int GLYPH_ROWS = tcgr_pkg::GLYPH_ROWS_DEF,
	parameter int CHAR_COUNT = tcgr_pkg::CHAR_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// s_tuser: command
	input  wire logic                          s_tuser,
	// s_tdata: char_code[7:0], glyph_row[11:8], glyph_bits[19:12], zero fill
	input  wire logic [tcgr_pkg::S_DATA_W-1:0] s_tdata,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// m_tuser: kind
	output logic                               m_tuser,
	// m_tdata: pixel_x[11:0], pixel_y[23:12], byte_address[55:24],
	//          row_bits[63:56], set_color[95:64], clear_color[127:96]
	output logic [tcgr_pkg::M_DATA_W-1:0]      m_tdata,
	output logic                               m_tlast,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tcgr_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [tcgr_pkg::CDATA_W-1:0]  cfg_data
);
	import tcgr_pkg::*;

	localparam int ROW_W = $clog2(GLYPH_ROWS);

	cmd_t               cmd;
	status_t            status;
	logic [ROW_W-1:0]   row;
	logic [PIX_W-1:0]   m_x, m_y;
	logic [ADDR_W-1:0]  m_addr;
	logic [BITS_W-1:0]  m_bits;
	logic [COLOR_W-1:0] m_set, m_clr;

	assign cfg_ready = 1'b1;

	tcgr_ctrl #(
		.GLYPH_ROWS(GLYPH_ROWS),
		.ROW_W     (ROW_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_cmd   (s_tuser),
		.status  (status),
		.cmd     (cmd),
		.row     (row)
	);

	tcgr_datapath #(
		.GLYPH_ROWS(GLYPH_ROWS),
		.CHAR_COUNT(CHAR_COUNT),
		.ROW_W     (ROW_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.row      (row),
		.status   (status),
		.in_code  (s_tdata[7:0]),
		.in_grow  (s_tdata[11:8]),
		.in_bits  (s_tdata[19:12]),
		.cfg_valid(cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_kind   (m_tuser),
		.m_last   (m_tlast),
		.m_x      (m_x),
		.m_y      (m_y),
		.m_addr   (m_addr),
		.m_bits   (m_bits),
		.m_set    (m_set),
		.m_clr    (m_clr)
	);

	// Pack the result beat
	assign m_tdata = {m_clr, m_set, m_bits, m_addr, m_y, m_x};

	// A clear request carries an all-zero payload
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_CLEAR) |-> (m_tdata == '0))
		else $error("clear beat with non-zero payload");

	// Never push a beat into a stalled row stage
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_row || cmd.push_clear) |-> status.advance)
		else $error("push into stalled row stage");

	// At most one datapath action per cycle
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push_row, cmd.push_clear, cmd.do_move, cmd.do_setup, cmd.do_adv}))
		else $error("overlapping datapath actions");

	// Input is taken only while no character is in progress
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_row |-> !s_tready)
		else $error("input ready during row issue");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking bench for text_console_glyph_renderer_top: directed and random beats.
// Depends on tcgr_pkg and the renderer RTL; a scoreboard class predicts every output beat.
`timescale 1ns / 1ps

module testbench;
	import tcgr_pkg::*;

	localparam int GLYPH_ROWS    = GLYPH_ROWS_DEF;
	localparam int CHAR_COUNT    = CHAR_COUNT_DEF;
	localparam int CUR_MASK      = (1 << CUR_W) - 1;
	localparam int SETTLE_CYCLES = GLYPH_ROWS + 16;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SHOW_LIMIT    = 10;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 22;
	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

	// One output beat as seen on the master side
	typedef struct {
		logic                kind;
		logic [PIX_W-1:0]    px;
		logic [PIX_W-1:0]    py;
		logic [ADDR_W-1:0]   addr;
		logic [BITS_W-1:0]   bits;
		logic [COLOR_W-1:0]  fg;
		logic [COLOR_W-1:0]  bg;
		logic                last;
	} row_beat_t;

	// Console predictor: own copy of registers, cursor and font, plus beats still due
	class glyph_row_scoreboard;
		int unsigned width, height, pitch, bpp, fore, back, tab;
		int unsigned cur_x, cur_y;
		logic [BITS_W-1:0] font_rows [GLYPH_ROWS*CHAR_COUNT];
		row_beat_t rows_due[$];
		int errors;

		function new();
			width  = 640;
			height = 480;
			pitch  = 2560;
			bpp    = 4;
			fore   = 32'hFFFF_FFFF;
			back   = 0;
			tab    = 4;
			cur_x  = 0;
			cur_y  = 0;
			errors = 0;
		endfunction

		function int pending();
			return rows_due.size();
		endfunction

		function void note_config(logic [IDX_W-1:0] idx, logic [CDATA_W-1:0] data);
			case (idx)
				REG_WIDTH:  width  = 32'(data[CUR_W-1:0]);
				REG_HEIGHT: height = 32'(data[CUR_W-1:0]);
				REG_PITCH:  pitch  = 32'(data[15:0]);
				REG_BPP:    bpp    = 32'(data[2:0]);
				REG_FORE:   fore   = data;
				REG_BACK:   back   = data;
				REG_TAB:    tab    = 32'(data[4:0]);
				default: ;
			endcase
		endfunction

		function void new_line();
			cur_x = 0;
			cur_y = (cur_y + GLYPH_ROWS) & CUR_MASK;
		endfunction

		// Advance the console by one input beat and queue the beats it causes
		function void note_item(logic cmd, logic [CODE_W-1:0] code, logic [GROW_W-1:0] grow,
				logic [BITS_W-1:0] gbits);
			row_beat_t b;
			int unsigned yr, cells;
			bit ctrl;
			if (cmd == CMD_FONT) begin
				if (grow < GLYPH_ROWS)
					font_rows[code*GLYPH_ROWS + grow] = gbits;
				return;
			end
			ctrl = (code == CH_NUL || code == CH_BS || code == CH_TAB || code == CH_LF);
			// Bottom reached: request a clear and home the cursor first
			if (cur_y + GLYPH_ROWS > height) begin
				b = '{kind: KIND_CLEAR, px: '0, py: '0, addr: '0, bits: '0, fg: '0, bg: '0,
					last: ctrl};
				rows_due.push_back(b);
				back  = 0;
				cur_x = 0;
				cur_y = 0;
			end
			case (code)
				CH_TAB: begin
					cur_x = (cur_x + GLYPH_COLUMNS*tab) & CUR_MASK;
					if (cur_x + GLYPH_COLUMNS > width)
						new_line();
				end
				CH_LF: new_line();
				CH_BS: begin
					if (cur_x == 0 && cur_y != 0) begin
						cells = width / GLYPH_COLUMNS;
						cur_x = (cells > 0) ? (cells - 1)*GLYPH_COLUMNS : 0;
						cur_y = (cur_y >= GLYPH_ROWS) ? cur_y - GLYPH_ROWS : 0;
					end else if (cur_x != 0) begin
						cur_x = (cur_x >= GLYPH_COLUMNS) ? cur_x - GLYPH_COLUMNS : 0;
					end
				end
				CH_NUL: ;
				default: begin
					for (int r = 0; r < GLYPH_ROWS; r++) begin
						yr = cur_y + r;
						b.kind = KIND_ROW;
						b.px   = cur_x[PIX_W-1:0];
						b.py   = yr[PIX_W-1:0];
						b.addr = yr*pitch + cur_x*bpp;
						b.bits = font_rows[code*GLYPH_ROWS + r];
						b.fg   = fore;
						b.bg   = back;
						b.last = (r == GLYPH_ROWS - 1);
						rows_due.push_back(b);
					end
					cur_x = (cur_x + GLYPH_COLUMNS) & CUR_MASK;
					if (cur_x + GLYPH_COLUMNS > width)
						new_line();
				end
			endcase
		endfunction

		// Compare one accepted beat with the oldest one due
		function void check_beat(row_beat_t got);
			row_beat_t want;
			if (rows_due.size() == 0) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("%0t: beat with nothing due: kind=%0d x=%0d y=%0d addr=%h",
						$realtime, got.kind, got.px, got.py, got.addr);
				return;
			end
			want = rows_due.pop_front();
			if (got.kind !== want.kind || got.px !== want.px || got.py !== want.py ||
					got.addr !== want.addr || got.bits !== want.bits || got.fg !== want.fg ||
					got.bg !== want.bg || got.last !== want.last) begin
				errors++;
				if (errors <= SHOW_LIMIT) begin
					$display("%0t: beat mismatch", $realtime);
					$display("  want kind=%0d x=%0d y=%0d addr=%h bits=%h fg=%h bg=%h last=%0d",
						want.kind, want.px, want.py, want.addr, want.bits, want.fg, want.bg,
						want.last);
					$display("  got  kind=%0d x=%0d y=%0d addr=%h bits=%h fg=%h bg=%h last=%0d",
						got.kind, got.px, got.py, got.addr, got.bits, got.fg, got.bg, got.last);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tuser   = 1'b0;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic                  m_tuser;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [CDATA_W-1:0]    cfg_data  = '0;

	glyph_row_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet = 0;
	logic [GLYPH_ROWS-1:0] glyph_seen [CHAR_COUNT];
	logic [CODE_W-1:0] loaded_glyphs[$];

	text_console_glyph_renderer_top #(
		.GLYPH_ROWS(GLYPH_ROWS),
		.CHAR_COUNT(CHAR_COUNT)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Check each accepted output beat, then draw the next receiver stall
	always @(posedge clk) begin : watch_rows
		row_beat_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.px   = m_tdata[11:0];
			got.py   = m_tdata[23:12];
			got.addr = m_tdata[55:24];
			got.bits = m_tdata[63:56];
			got.fg   = m_tdata[95:64];
			got.bg   = m_tdata[127:96];
			got.last = m_tlast;
			sb.check_beat(got);
		end
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Drop the run once no channel has moved a beat for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one input beat after a random gap and hold it until taken
	task automatic send_item(logic cmd, logic [CODE_W-1:0] code, logic [GROW_W-1:0] grow,
			logic [BITS_W-1:0] gbits);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(S_DATA_W-20){1'b0}}, gbits, grow, code};
		do @(posedge clk); while (!s_tready);
		sb.note_item(cmd, code, grow, gbits);
		if (cmd == CMD_FONT)
			glyph_seen[code][grow] = 1'b1;
	endtask

	task automatic put_char(logic [CODE_W-1:0] code);
		send_item(CMD_PUT, code, GROW_W'($urandom), BITS_W'($urandom));
	endtask

	// Fill every unwritten row of a glyph so that printing it reads only written rows
	task automatic load_glyph(logic [CODE_W-1:0] code);
		for (int r = 0; r < GLYPH_ROWS; r++)
			if (!glyph_seen[code][r])
				send_item(CMD_FONT, code, GROW_W'(r), BITS_W'($urandom));
		loaded_glyphs.push_back(code);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CDATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.note_config(idx, data);
	endtask

	task automatic configure(int unsigned w, int unsigned h, int unsigned p, int unsigned b,
			logic [31:0] fg, logic [31:0] bg, int unsigned t);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_PITCH, p);
		write_reg(REG_BPP, b);
		write_reg(REG_FORE, fg);
		write_reg(REG_BACK, bg);
		write_reg(REG_TAB, t);
		cfg_valid <= 1'b0;
	endtask

	// Drop the input, wait for every due beat, then let any silent work finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic directed_part();
		font_write_extremes: begin
			send_item(CMD_FONT, 8'hFF, 4'd0, 8'h00);
			send_item(CMD_FONT, 8'hFF, 4'd15, 8'hFF);
		end
		load_glyph(8'hFF);
		load_glyph(8'h01);
		load_glyph(8'h80);
		// Reset settings: nothing codes, backspace at home and at column zero, tab overflow
		put_char(CH_NUL);
		put_char(CH_BS);
		put_char(8'hFF);
		put_char(CH_BS);
		put_char(8'h01);
		put_char(CH_LF);
		put_char(CH_BS);
		put_char(8'h80);
		put_char(CH_BS);
		put_char(CH_TAB);
		settle();
		// Narrowest, shortest screen: clears before a glyph and before a tab
		write_reg(REG_NONE, 32'hDEAD_BEEF);
		configure(8, 16, 65535, 1, 32'h0, 32'hFFFF_FFFF, 16);
		put_char(8'h01);
		put_char(CH_TAB);
		settle();
		// Backspace at column zero of a one-cell line
		write_reg(REG_HEIGHT, 48);
		cfg_valid <= 1'b0;
		put_char(CH_LF);
		put_char(CH_BS);
		settle();
		// Widest, tallest screen
		configure(4096, 4096, 65535, 4, 32'hFFFF_FFFF, 32'h1234_5678, 1);
		put_char(CH_TAB);
		put_char(8'hFF);
		put_char(8'h01);
		settle();
	endtask

	task automatic random_setup();
		int unsigned w, h, p;
		int pick;
		pick = $urandom_range(0, 99);
		w = (pick < 10) ? 8 : (pick < 15) ? 4096 : $urandom_range(8, 160);
		pick = $urandom_range(0, 99);
		h = (pick < 10) ? 16 : (pick < 14) ? 4096 : $urandom_range(16, 160);
		pick = $urandom_range(0, 99);
		p = (pick < 10) ? 1 : (pick < 20) ? 65535 : $urandom_range(1, 65535);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_NONE, $urandom);
		configure(w, h, p, $urandom_range(1, 4), $urandom,
			($urandom_range(0, 4) == 0) ? 32'h0 : $urandom, $urandom_range(1, 16));
	endtask

	// Mostly printable text with control codes mixed in; some stray font writes
	task automatic random_item();
		logic [CODE_W-1:0] code;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			send_item(CMD_FONT, CODE_W'($urandom), GROW_W'($urandom), BITS_W'($urandom));
		end else if (pick < 32) begin
			case ($urandom_range(0, 3))
				0: code = CH_NUL;
				1: code = CH_BS;
				2: code = CH_TAB;
				default: code = CH_LF;
			endcase
			put_char(code);
		end else begin
			if (loaded_glyphs.size() == 0 || $urandom_range(0, 99) < 5) begin
				do code = CODE_W'($urandom_range(1, CHAR_COUNT - 1));
				while (code == CH_BS || code == CH_TAB || code == CH_LF);
			end else begin
				code = loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)];
			end
			if (!(&glyph_seen[code]))
				load_glyph(code);
			put_char(code);
		end
	endtask

	initial begin
		sb = new();
		foreach (glyph_seen[c])
			glyph_seen[c] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 6;
		recv_idle_pct = 67;
		directed_part();
		for (int ph = 0; ph < PHASES; ph++) begin
			// Swap the idling pattern every two phases, last pair runs flat out
			case (ph / 2)
				0: begin
					send_idle_pct = 6;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 6;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			random_setup();
			for (int i = 0; i < PHASE_ITEMS; i++)
				random_item();
			settle();
		end
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
